// ===== hdl/utf_pkg.sv =====
// ----------------------------------------------------------------------------
// utf_pkg
// Shared types and constants of the UART transmit framer with byte FIFO.
// ----------------------------------------------------------------------------
package utf_pkg;

	localparam int FIFO_DEPTH = 16;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
	localparam int BYTE_W     = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;

	// input item kinds
	localparam logic ACT_TICK = 1'b0;
	localparam logic ACT_PUSH = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DATA_BITS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PARITY    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STOP_BITS = 2'd2;

	typedef enum logic [1:0] {
		PAR_NONE = 2'd0,
		PAR_ODD  = 2'd1,
		PAR_EVEN = 2'd2,
		PAR_MARK = 2'd3
	} parity_mode_t;

	typedef struct packed {
		logic tx_line;
		logic line_updated;
		logic push_rejected;
		logic queue_empty;
		logic line_idle;
	} result_t;

endpackage

// ===== hdl/utf_if.sv =====
// ----------------------------------------------------------------------------
// utf_cmd_if / utf_res_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface utf_cmd_if;
	import utf_pkg::*;

	logic              valid;
	logic              ready;
	logic              action;
	logic [BYTE_W-1:0] data_byte;

	modport source (output valid, output action, output data_byte, input ready);
	modport sink   (input valid, input action, input data_byte, output ready);
endinterface

interface utf_res_if;
	logic valid;
	logic ready;
	logic tx_line;
	logic line_updated;
	logic push_rejected;
	logic queue_empty;
	logic line_idle;

	modport source (output valid, output tx_line, output line_updated,
		output push_rejected, output queue_empty, output line_idle, input ready);
	modport sink   (input valid, input tx_line, input line_updated,
		input push_rejected, input queue_empty, input line_idle, output ready);
endinterface

// ===== hdl/utf_ram.sv =====
// ----------------------------------------------------------------------------
// utf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module utf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/uart_tx_framer_with_fifo.sv =====
// ----------------------------------------------------------------------------
// uart_tx_framer_with_fifo
// UART transmit framer fed from a byte FIFO, one bit per tick item.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries items: action = push enqueues data_byte, action = tick
//   advances the line by one bit time (start, 5..8 data bits LSB first,
//   optional parity, 1 or 2 stop bits). Every item yields one result on res.
//   cfg_wr_en/cfg_index/cfg_wdata write data bit count, parity mode and stop
//   bit count; write only while the block is idle.
// Timing:
//   One item per cycle while the skid entry is free; each result is registered
//   in the output register, or in the skid entry while res stalls. Per item the
//   FIFO pointers and frame counter are updated; the FIFO RAM read for a new
//   frame overlaps the start bit, so the byte is needed only from the next tick.
// Reset:
//   FIFO empty, no frame in progress, line high, 8 data bits, no parity,
//   one stop bit. FIFO RAM contents are not cleared.
// Stall:
//   A two-entry output stage (register plus skid) keeps cmd ready while one
//   result waits; cmd.ready drops only when both entries are full.
// ----------------------------------------------------------------------------
module uart_tx_framer_with_fifo (
	input  logic                               clk,
	input  logic                               arst_n,
	utf_cmd_if.sink                            cmd,
	utf_res_if.source                          res,
	input  logic                               cfg_wr_en,
	input  logic [utf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [utf_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import utf_pkg::*;

	// configuration
	logic [3:0]   data_bits_q;
	parity_mode_t parity_q;
	logic [1:0]   stop_bits_q;

	// transmit state
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic [BYTE_W-1:0] cur_byte_q;
	logic              load_pend_q;
	logic [3:0]        pos_q;
	logic              active_q;
	logic              line_q;

	// output stage
	logic    out_valid_q;
	result_t out_q;
	logic    skid_valid_q;
	result_t skid_q;

	logic              accept;
	logic              is_push;
	logic              is_tick;
	logic              full;
	logic              do_write;
	logic              do_load;
	logic [BYTE_W-1:0] ram_rdata;
	logic [BYTE_W-1:0] byte_cur;
	logic [3:0]        d_eff;
	logic [1:0]        s_eff;
	logic [3:0]        frame_end;
	logic              active_now;
	logic [3:0]        pos_use;
	logic [3:0]        pos_next;
	logic [2:0]        bit_idx;
	logic [BYTE_W-1:0] data_mask;
	logic              ones;
	logic              par_bit;
	logic              frame_bit;
	logic [CNT_W-1:0]  count_next;
	logic              active_next;
	logic              line_next;
	result_t           new_res;

	assign cmd.ready = !skid_valid_q;
	assign accept    = cmd.valid && cmd.ready;
	assign is_push   = accept && (cmd.action == ACT_PUSH);
	assign is_tick   = accept && (cmd.action == ACT_TICK);
	assign full      = (count_q == CNT_W'(FIFO_DEPTH));

	// effective layout of the frame
	always_comb begin
		if (data_bits_q < 4'd5) begin
			d_eff = 4'd5;
		end else if (data_bits_q > 4'd8) begin
			d_eff = 4'd8;
		end else begin
			d_eff = data_bits_q;
		end
		case (stop_bits_q)
			2'd0:    s_eff = 2'd1;
			2'd3:    s_eff = 2'd2;
			default: s_eff = stop_bits_q;
		endcase
	end

	assign frame_end  = 4'd1 + d_eff + {3'b000, parity_q != PAR_NONE} + {2'b00, s_eff};
	assign active_now = active_q && (pos_q < frame_end);
	assign do_write   = is_push && !full;
	assign do_load    = is_tick && !active_now && (count_q != '0);

	// byte read on a load arrives in the following cycle; the start bit does not need it
	assign byte_cur  = load_pend_q ? ram_rdata : cur_byte_q;
	assign data_mask = 8'hFF >> (4'd8 - d_eff);
	assign ones      = ^(byte_cur & data_mask);

	always_comb begin
		case (parity_q)
			PAR_ODD:  par_bit = !ones;
			PAR_EVEN: par_bit = ones;
			default:  par_bit = 1'b1;
		endcase
	end

	assign pos_use  = do_load ? 4'd0 : pos_q;
	assign pos_next = pos_use + 4'd1;
	assign bit_idx  = 3'(pos_use - 4'd1);

	always_comb begin
		if (pos_use == 4'd0) begin
			frame_bit = 1'b0;
		end else if (pos_use <= d_eff) begin
			frame_bit = byte_cur[bit_idx];
		end else if ((parity_q != PAR_NONE) && (pos_use == d_eff + 4'd1)) begin
			frame_bit = par_bit;
		end else begin
			frame_bit = 1'b1;
		end
	end

	always_comb begin
		count_next  = count_q;
		active_next = active_now;
		line_next   = line_q;
		if (do_write) begin
			count_next = count_q + CNT_W'(1);
		end
		if (do_load) begin
			count_next = count_q - CNT_W'(1);
		end
		if (is_tick && (active_now || do_load)) begin
			line_next   = frame_bit;
			active_next = pos_next < frame_end;
		end
	end

	always_comb begin
		new_res.tx_line       = line_next;
		new_res.line_updated  = is_tick && (active_now || do_load);
		new_res.push_rejected = is_push && full;
		new_res.queue_empty   = (count_next == '0);
		new_res.line_idle     = !active_next && (count_next == '0);
	end

	utf_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (FIFO_DEPTH)
	) u_fifo_ram (
		.clk   (clk),
		.we    (do_write),
		.waddr (wr_ptr_q),
		.wdata (cmd.data_byte),
		.re    (do_load),
		.raddr (rd_ptr_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_bits_q <= 4'd8;
			parity_q    <= PAR_NONE;
			stop_bits_q <= 2'd1;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_DATA_BITS: data_bits_q <= cfg_wdata[3:0];
				CFG_PARITY:    parity_q    <= parity_mode_t'(cfg_wdata[1:0]);
				CFG_STOP_BITS: stop_bits_q <= cfg_wdata[1:0];
				default:       ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q    <= '0;
			wr_ptr_q    <= '0;
			count_q     <= '0;
			load_pend_q <= 1'b0;
			pos_q       <= '0;
			active_q    <= 1'b0;
			line_q      <= 1'b1;
		end else begin
			load_pend_q <= do_load;
			if (accept) begin
				count_q  <= count_next;
				active_q <= active_next;
				line_q   <= line_next;
			end
			if (do_write) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_load) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (is_tick && (active_now || do_load)) begin
				pos_q <= pos_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_pend_q) begin
			cur_byte_q <= ram_rdata;
		end
	end

	// output register plus skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || res.ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept;
			end
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || res.ready) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (accept) begin
				out_q <= new_res;
			end
		end else if (accept) begin
			skid_q <= new_res;
		end
	end

	assign res.valid         = out_valid_q;
	assign res.tx_line       = out_q.tx_line;
	assign res.line_updated  = out_q.line_updated;
	assign res.push_rejected = out_q.push_rejected;
	assign res.queue_empty   = out_q.queue_empty;
	assign res.line_idle     = out_q.line_idle;

endmodule

// ===== dv/tb_uart_tx_framer_with_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_uart_tx_framer_with_fifo
// Self-checking bench for the UART transmit framer. Pushes and bit ticks go in
// over the command channel, and a line-level model predicts every result.
// The run covers fixed frames, FIFO overflow, every data bit count, parity mode
// and stop code with out-of-range codes, format changes mid-frame, output back-pressure and
// random traffic under several idling mixes.
// ----------------------------------------------------------------------------
module tb_uart_tx_framer_with_fifo;
	import utf_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int FRAME_MAX   = 12;
	localparam int PRINT_MAX   = 40;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	utf_cmd_if cmd_ch ();
	utf_res_if res_ch ();

	uart_tx_framer_with_fifo u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.res       (res_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// line model state
	logic [BYTE_W-1:0] mdl_fifo [FIFO_DEPTH];
	int                mdl_rd;
	int                mdl_wr;
	int                mdl_count;
	logic [BYTE_W-1:0] mdl_byte;
	logic [3:0]        mdl_pos;
	logic              mdl_active;
	logic              mdl_line;
	logic [3:0]        mdl_data_bits;
	parity_mode_t      mdl_parity;
	logic [1:0]        mdl_stop_bits;

	result_t pending_results [$];
	string   field_names [5] = '{"tx_line", "line_updated", "push_rejected",
		"queue_empty", "line_idle"};

	int mismatch_count;
	int results_seen;
	int items_sent;
	int pushes_dropped;
	int frames_started;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_left;
	int cycle_count;

	always #1 clk = ~clk;

	function automatic int data_bits_eff();
		if (mdl_data_bits < 5) return 5;
		if (mdl_data_bits > 8) return 8;
		return int'(mdl_data_bits);
	endfunction

	function automatic int frame_end();
		int stop_n;
		stop_n = (mdl_stop_bits == 2'd0) ? 1 : (mdl_stop_bits == 2'd3) ? 2 : int'(mdl_stop_bits);
		return 1 + data_bits_eff() + ((mdl_parity != PAR_NONE) ? 1 : 0) + stop_n;
	endfunction

	function automatic result_t predict_line(logic act, logic [BYTE_W-1:0] b);
		result_t           r;
		int                nd;
		logic              updated;
		logic              dropped;
		logic [BYTE_W-1:0] mask;
		updated = 1'b0;
		dropped = 1'b0;
		// a format change may have cut the frame short
		if (mdl_active && mdl_pos >= frame_end()) mdl_active = 1'b0;
		if (act == ACT_PUSH) begin
			if (mdl_count >= FIFO_DEPTH) begin
				dropped = 1'b1;
				pushes_dropped++;
			end else begin
				mdl_fifo[mdl_wr] = b;
				mdl_wr = (mdl_wr + 1) % FIFO_DEPTH;
				mdl_count++;
			end
		end else begin
			if (!mdl_active && mdl_count != 0) begin
				mdl_byte = mdl_fifo[mdl_rd];
				mdl_rd = (mdl_rd + 1) % FIFO_DEPTH;
				mdl_count--;
				mdl_pos = 4'd0;
				mdl_active = 1'b1;
				frames_started++;
			end
			if (mdl_active) begin
				nd = data_bits_eff();
				mask = BYTE_W'((1 << nd) - 1);
				if (mdl_pos == 4'd0) begin
					mdl_line = 1'b0;
				end else if (mdl_pos <= nd) begin
					mdl_line = mdl_byte[mdl_pos - 4'd1];
				end else if (mdl_parity != PAR_NONE && mdl_pos == nd + 1) begin
					case (mdl_parity)
						PAR_ODD:  mdl_line = ~^(mdl_byte & mask);
						PAR_EVEN: mdl_line = ^(mdl_byte & mask);
						default:  mdl_line = 1'b1;
					endcase
				end else begin
					mdl_line = 1'b1;
				end
				mdl_pos = mdl_pos + 4'd1;
				updated = 1'b1;
				if (mdl_pos >= frame_end()) mdl_active = 1'b0;
			end
		end
		r.tx_line       = mdl_line;
		r.line_updated  = updated;
		r.push_rejected = dropped;
		r.queue_empty   = (mdl_count == 0);
		r.line_idle     = !mdl_active && mdl_count == 0;
		return r;
	endfunction

	task automatic report_mismatch(string what);
		mismatch_count++;
		if (mismatch_count <= PRINT_MAX) $display("MISMATCH cycle %0d: %s", cycle_count, what);
	endtask

	// result checker and receiver back-pressure
	always @(posedge clk) begin : res_monitor
		result_t    got;
		result_t    want;
		logic [4:0] diff;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got.tx_line       = res_ch.tx_line;
			got.line_updated  = res_ch.line_updated;
			got.push_rejected = res_ch.push_rejected;
			got.queue_empty   = res_ch.queue_empty;
			got.line_idle     = res_ch.line_idle;
			results_seen++;
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with no item outstanding",
					results_seen));
			end else begin
				want = pending_results.pop_front();
				diff = got ^ want;
				for (int i = 0; i < 5; i++) begin
					if (diff[4-i]) begin
						report_mismatch($sformatf("result %0d %s: got %b, expected %b",
							results_seen, field_names[i], got[4-i], want[4-i]));
					end
				end
			end
		end
		if (hold_left != 0) begin
			res_ch.ready <= 1'b0;
			hold_left    <= hold_left - 1;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TIMEOUT after %0d cycles, %0d results outstanding", cycle_count,
				pending_results.size());
			$display("simulation failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// shared driving tasks
	// ------------------------------------------------------------------------
	task automatic send_item(logic act, logic [BYTE_W-1:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid     <= 1'b1;
		cmd_ch.action    <= act;
		cmd_ch.data_byte <= b;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		pending_results.push_back(predict_line(act, b));
		items_sent++;
	endtask

	task automatic wait_for_results();
		cmd_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_idling(int ph);
		case (ph % 4)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
			default: begin send_idle_pct = 26; recv_stall_pct = 26; end
		endcase
	endtask

	// upper bits of the parity and stop codes are junk the block must mask
	task automatic set_frame_format(int d, parity_mode_t p, int s);
		wait_for_results();
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_DATA_BITS;
		cfg_wdata <= CFG_DATA_W'(d);
		@(posedge clk);
		mdl_data_bits = 4'(d);
		cfg_index <= CFG_PARITY;
		cfg_wdata <= {2'($urandom_range(3)), p};
		@(posedge clk);
		mdl_parity = p;
		cfg_index <= CFG_STOP_BITS;
		cfg_wdata <= {2'($urandom_range(3)), 2'(s)};
		@(posedge clk);
		mdl_stop_bits = 2'(s);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic run_traffic(int n, int push_pct);
		repeat (n) begin
			send_item(($urandom_range(99) < push_pct) ? ACT_PUSH : ACT_TICK, BYTE_W'($urandom));
		end
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------
	task automatic test_directed_frames();
		set_idling(0);
		send_item(ACT_TICK, 8'h00);
		send_item(ACT_PUSH, 8'hFF);
		send_item(ACT_PUSH, 8'h00);
		// two full 8N1 frames and one idle tick
		repeat (21) send_item(ACT_TICK, 8'hFF);
		wait_for_results();
	endtask

	task automatic test_fifo_overflow();
		set_idling(3);
		repeat (FIFO_DEPTH + 4) send_item(ACT_PUSH, BYTE_W'($urandom));
		repeat (2 * FRAME_MAX) send_item(ACT_TICK, BYTE_W'($urandom));
		run_traffic(40, 50);
		wait_for_results();
	endtask

	task automatic test_frame_formats();
		int fmt_bits [8] = '{5, 8, 6, 7, 0, 15, 4, 9};
		int push_mix [3] = '{10, 25, 40};
		for (int k = 0; k < 16; k++) begin
			set_frame_format(fmt_bits[k % 8], parity_mode_t'(k % 4), (k >> 2) % 4);
			set_idling(k);
			run_traffic(44, push_mix[k % 3]);
		end
		wait_for_results();
	endtask

	task automatic test_mid_frame_reformat();
		set_idling(0);
		set_frame_format(8, PAR_EVEN, 2);
		send_item(ACT_PUSH, BYTE_W'($urandom));
		repeat (10) send_item(ACT_TICK, BYTE_W'($urandom));
		// position now past the end of the shorter frame
		set_frame_format(5, PAR_NONE, 1);
		send_item(ACT_PUSH, BYTE_W'($urandom));
		repeat (9) send_item(ACT_TICK, BYTE_W'($urandom));
		set_frame_format(8, PAR_ODD, 3);
		send_item(ACT_PUSH, BYTE_W'($urandom));
		repeat (4) send_item(ACT_TICK, BYTE_W'($urandom));
		// shrink while still inside the data bits
		set_frame_format(6, PAR_MARK, 0);
		repeat (10) send_item(ACT_TICK, BYTE_W'($urandom));
		wait_for_results();
	endtask

	task automatic test_output_hold();
		set_idling(0);
		hold_left <= 400;
		run_traffic(40, 30);
		wait_for_results();
	endtask

	task automatic test_sender_pause();
		set_idling(2);
		repeat (4) begin
			run_traffic(25, 30);
			wait_for_results();
		end
	endtask

	task automatic test_random_mix();
		for (int ph = 0; ph < 12; ph++) begin
			set_frame_format($urandom_range(15), parity_mode_t'($urandom_range(3)),
				$urandom_range(3));
			set_idling(ph);
			run_traffic(45, $urandom_range(5, 45));
		end
		wait_for_results();
	endtask

	initial begin
		arst_n           = 1'b0;
		cmd_ch.valid     = 1'b0;
		cmd_ch.action    = ACT_TICK;
		cmd_ch.data_byte = '0;
		res_ch.ready     = 1'b0;
		cfg_wr_en        = 1'b0;
		cfg_index        = CFG_DATA_BITS;
		cfg_wdata        = '0;
		mismatch_count   = 0;
		results_seen     = 0;
		items_sent       = 0;
		pushes_dropped   = 0;
		frames_started   = 0;
		send_idle_pct    = 0;
		recv_stall_pct   = 0;
		hold_left        = 0;
		cycle_count      = 0;
		mdl_rd           = 0;
		mdl_wr           = 0;
		mdl_count        = 0;
		mdl_byte         = '0;
		mdl_pos          = 4'd0;
		mdl_active       = 1'b0;
		mdl_line         = 1'b1;
		mdl_data_bits    = 4'd8;
		mdl_parity       = PAR_NONE;
		mdl_stop_bits    = 2'd1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_frames();
		test_fifo_overflow();
		test_frame_formats();
		test_mid_frame_reformat();
		test_output_hold();
		test_sender_pause();
		test_random_mix();

		wait_for_results();
		repeat (FRAME_MAX) @(posedge clk);
		$display("Run: %0d items, %0d results checked, %0d frames, %0d pushes dropped, %0d cycles.",
			items_sent, results_seen, frames_started, pushes_dropped, cycle_count);
		$display("Formats 5..8 data bits (and out-of-range codes), all parity modes, 1..2 stop bits.");
		if (mismatch_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/utf_pkg.sv
hdl/utf_if.sv
hdl/utf_ram.sv
hdl/uart_tx_framer_with_fifo.sv
dv/tb_uart_tx_framer_with_fifo.sv
